// ----- hw/rtl/memcomparable_bytes_codec_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the memcomparable bytes codec
// Shared property shapes for the codec checkers.
// ---------------------------------------------------------------------------
`ifndef MEMCOMPARABLE_BYTES_CODEC_ASSERT_SVH
`define MEMCOMPARABLE_BYTES_CODEC_ASSERT_SVH

// Same-cycle implication, masked while in reset
`define MBC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while in reset
`define MBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset
`define MBC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mbc_pkg.sv -----
// ---------------------------------------------------------------------------
// mbc_pkg
// Constants and types shared by the memcomparable bytes codec.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbc_pkg;

    // Data bytes per group (a marker byte follows each group)
    localparam int GROUP_BYTES = 8;
    // Most result items one request can cause
    localparam int MAX_ITEMS   = GROUP_BYTES + 3;

    localparam int POS_W = $clog2(GROUP_BYTES + 1);
    localparam int IDX_W = $clog2(GROUP_BYTES);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [7:0] MARK_FULL = 8'hFF;
    localparam logic [7:0] MARK_MIN  = 8'(255 - GROUP_BYTES);

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_in;

    typedef struct packed {
        logic       bad;
        logic       vend;
        logic       valid;
        logic [7:0] data;
    } t_item;

    typedef t_item [MAX_ITEMS-1:0] t_item_list;
    typedef logic [GROUP_BYTES-1:0][7:0] t_group;

    // Expander control towards the top level
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] pos_next;
        logic             buf_we;
    } t_exp_ctl;

endpackage

// ----- hw/rtl/mbc_expand.sv -----
// ---------------------------------------------------------------------------
// mbc_expand
// Turns one request into the list of result items it causes, plus the
// next group position and the group buffer write strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbc_expand (
    input  logic                      i_mode,
    input  mbc_pkg::t_in              i_in,
    input  logic [mbc_pkg::POS_W-1:0] i_pos,
    input  mbc_pkg::t_group           i_group,
    output mbc_pkg::t_item_list       o_items,
    output mbc_pkg::t_exp_ctl         o_ctl
);

    always_comb begin
        logic                      s;
        logic                      full;
        logic [mbc_pkg::POS_W-1:0] pos_a;
        logic [mbc_pkg::POS_W-1:0] pad;
        logic [mbc_pkg::CNT_W-1:0] e1;
        logic [mbc_pkg::CNT_W-1:0] e2;
        logic [mbc_pkg::CNT_W-1:0] e3;
        logic [7:0]                pad8;
        logic [mbc_pkg::POS_W-1:0] keep;

        o_items = '0;
        o_ctl   = '0;
        s       = 1'b0;
        full    = 1'b0;
        pos_a   = '0;
        pad     = '0;
        e1      = '0;
        e2      = '0;
        e3      = '0;
        pad8    = '0;
        keep    = '0;

        if (i_mode == mbc_pkg::MODE_ENCODE) begin
            // byte if present, full marker if the group fills, then on the last request padding zeros and end marker
            s     = i_in.present;
            full  = s && (i_pos == mbc_pkg::POS_W'(mbc_pkg::GROUP_BYTES - 1));
            pos_a = full ? '0 : i_pos + mbc_pkg::POS_W'(s);
            pad   = mbc_pkg::POS_W'(mbc_pkg::GROUP_BYTES) - pos_a;
            e1    = mbc_pkg::CNT_W'(s);
            e2    = e1 + mbc_pkg::CNT_W'(full);
            e3    = e2 + (i_in.last ? mbc_pkg::CNT_W'(pad) : '0);
            o_ctl.count    = e3 + mbc_pkg::CNT_W'(i_in.last);
            o_ctl.pos_next = i_in.last ? '0 : pos_a;
            for (int k = 0; k < mbc_pkg::MAX_ITEMS; k++) begin
                o_items[k].valid = 1'b1;
                if (mbc_pkg::CNT_W'(k) < e1) begin
                    o_items[k].data = i_in.data;
                end else if (mbc_pkg::CNT_W'(k) < e2) begin
                    o_items[k].data = mbc_pkg::MARK_FULL;
                end else if (mbc_pkg::CNT_W'(k) < e3) begin
                    o_items[k].data = 8'h00;
                end else begin
                    o_items[k].data = mbc_pkg::MARK_FULL - 8'(pad);
                    o_items[k].vend = 1'b1;
                end
            end
        end else if (i_pos < mbc_pkg::POS_W'(mbc_pkg::GROUP_BYTES)) begin
            // decode: group data byte, buffered only
            o_ctl.buf_we   = 1'b1;
            o_ctl.pos_next = i_pos + mbc_pkg::POS_W'(1);
        end else if (i_in.data == mbc_pkg::MARK_FULL) begin
            // decode: full group, value continues
            o_ctl.count = mbc_pkg::CNT_W'(mbc_pkg::GROUP_BYTES);
            for (int k = 0; k < mbc_pkg::GROUP_BYTES; k++) begin
                o_items[k].data  = i_group[mbc_pkg::IDX_W'(k)];
                o_items[k].valid = 1'b1;
            end
        end else if (i_in.data < mbc_pkg::MARK_MIN) begin
            // decode: corrupt marker aborts the value
            o_ctl.count     = mbc_pkg::CNT_W'(1);
            o_items[0].vend = 1'b1;
            o_items[0].bad  = 1'b1;
        end else begin
            // decode: final group, emit the real bytes only
            pad8 = mbc_pkg::MARK_FULL - i_in.data;
            keep = mbc_pkg::POS_W'(mbc_pkg::GROUP_BYTES) - pad8[mbc_pkg::POS_W-1:0];
            if (keep == '0) begin
                o_ctl.count     = mbc_pkg::CNT_W'(1);
                o_items[0].vend = 1'b1;
            end else begin
                o_ctl.count = mbc_pkg::CNT_W'(keep);
                for (int k = 0; k < mbc_pkg::GROUP_BYTES; k++) begin
                    o_items[k].data  = i_group[mbc_pkg::IDX_W'(k)];
                    o_items[k].valid = 1'b1;
                    o_items[k].vend  = (mbc_pkg::POS_W'(k) + mbc_pkg::POS_W'(1) == keep);
                end
            end
        end
    end

endmodule

// ----- hw/rtl/memcomparable_bytes_codec.sv -----
// ---------------------------------------------------------------------------
// memcomparable_bytes_codec
// Order-preserving byte-string key codec with 8-byte groups and a marker
// byte after each group; encodes or decodes as set by the mode register.
// ---------------------------------------------------------------------------
//  channel  | direction | tdata            | tlast      | tuser (low bit up)
//  s_axis   | in        | data_byte        | value_last | byte_present
//  m_axis   | out       | out_byte         | value_end  | byte_valid, run_last,
//           |           |                  |            | bad_marker
//  cfg      | in        | codec_mode (i_cfg_wdata, written on i_cfg_we)
//
// A request passes an input register, then is expanded into an output shift
// register that holds all its result items (at most 11), which leave it one
// after another; a request with no result passes the input register without
// touching the output.
// Output stalls hold the shift register and, once it is busy, the input.
// Reset is synchronous; no clearing pass, the group buffer is never cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module memcomparable_bytes_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,     // codec_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  logic       s_axis_tlast,    // value_last
    input  logic       s_axis_tuser,    // [0] byte_present
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast,    // value_end
    output logic [2:0] m_axis_tuser     // [0] byte_valid [1] run_last [2] bad_marker
);

    logic                      r_mode;
    logic                      n_mode;
    logic [mbc_pkg::POS_W-1:0] r_pos;
    logic [mbc_pkg::POS_W-1:0] n_pos;
    mbc_pkg::t_group           r_group;
    logic                      r_in_v;
    logic                      n_in_v;
    mbc_pkg::t_in              r_in;
    mbc_pkg::t_item_list       r_items;
    mbc_pkg::t_item_list       exp_items;
    mbc_pkg::t_exp_ctl         exp_ctl;
    logic [mbc_pkg::CNT_W-1:0] r_cnt;
    logic [mbc_pkg::CNT_W-1:0] n_cnt;
    logic                      in_take;
    logic                      out_take;
    logic                      free;
    logic                      load;

    // Handshakes: output register frees up as its last item leaves
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign free          = (r_cnt == '0) || ((r_cnt == mbc_pkg::CNT_W'(1)) && m_axis_tready);
    assign load          = r_in_v && free;
    assign s_axis_tready = !r_in_v || load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    mbc_expand u_expand (
        .i_mode  (r_mode),
        .i_in    (r_in),
        .i_pos   (r_pos),
        .i_group (r_group),
        .o_items (exp_items),
        .o_ctl   (exp_ctl)
    );

    // Next-state logic
    always_comb begin
        n_in_v = r_in_v;
        if (in_take) begin
            n_in_v = 1'b1;
        end else if (load) begin
            n_in_v = 1'b0;
        end

        n_mode = r_mode;
        n_pos  = r_pos;
        if (i_cfg_we) begin
            n_mode = i_cfg_wdata;
            n_pos  = '0;
        end else if (load) begin
            n_pos = exp_ctl.pos_next;
        end

        n_cnt = r_cnt;
        if (load) begin
            n_cnt = exp_ctl.count;
        end else if (out_take) begin
            n_cnt = r_cnt - mbc_pkg::CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_mode <= mbc_pkg::MODE_ENCODE;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else begin
            r_in_v <= n_in_v;
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
        end
    end

    // Payload: input register, group buffer, result shift register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= '{data: s_axis_tdata, present: s_axis_tuser, last: s_axis_tlast};
        end
        if (load && exp_ctl.buf_we) begin
            r_group[r_pos[mbc_pkg::IDX_W-1:0]] <= r_in.data;
        end
        if (load) begin
            r_items <= exp_items;
        end else if (out_take) begin
            for (int k = 0; k < mbc_pkg::MAX_ITEMS - 1; k++) begin
                r_items[k] <= r_items[k+1];
            end
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_items[0].data;
    assign m_axis_tlast  = r_items[0].vend;
    assign m_axis_tuser  = {r_items[0].bad, (r_cnt == mbc_pkg::CNT_W'(1)), r_items[0].valid};

endmodule

// ----- hw/rtl/mbc_checker.sv -----
// ---------------------------------------------------------------------------
// mbc_checker
// Port-level checks on the codec's result stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "memcomparable_bytes_codec_assert.svh"

module mbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [2:0] m_axis_tuser
);

    // a stalled result holds
    `MBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}),
        "stalled result changed")
    // a value always ends on the last item of its request
    `MBC_ASSERT_IMPLY(a_end_is_run_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast, m_axis_tuser[1],
        "value end before request end")
    // a bare or aborted end stands alone and closes the value
    `MBC_ASSERT_IMPLY(a_bare_end, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && m_axis_tuser[1],
        "bare item not a lone value end")
    // a bad marker never carries a byte
    `MBC_ASSERT_IMPLY(a_bad_no_byte, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[2], !m_axis_tuser[0] && m_axis_tdata == 8'h00,
        "bad marker carries data")
    // nothing is offered straight after reset
    `MBC_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !m_axis_tvalid,
        "result offered after reset")

endmodule

bind memcomparable_bytes_codec mbc_checker u_mbc_checker (.*);
